// File: rtl/ilpw_pkg.sv
// Shared types, codes and reset values for the input lock progress watchdog.
package ilpw_pkg;

  // Field widths.
  localparam int unsigned TimeW  = 32;
  localparam int unsigned DepthW = 17;
  localparam int unsigned PosW   = 24;
  localparam int unsigned RegW   = 32;
  localparam int unsigned CfgIdxW = 2;

  // Register reset values.
  localparam logic [RegW-1:0] GraceReset     = 32'd300;
  localparam logic [RegW-1:0] StallReset     = 32'd4000;
  localparam logic [RegW-1:0] CeilingReset   = 32'd8000;
  localparam logic [RegW-1:0] ThresholdReset = 32'd16384;

  // Register indexes on the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    REG_GRACE     = 2'd0,
    REG_STALL     = 2'd1,
    REG_CEILING   = 2'd2,
    REG_THRESHOLD = 2'd3
  } reg_idx_e;

  // Operation carried by one input word.
  typedef enum logic [1:0] {
    MODE_ENABLE  = 2'd0,
    MODE_ARM     = 2'd1,
    MODE_SUSTAIN = 2'd2,
    MODE_TICK    = 2'd3
  } mode_e;

  // Why a tick asked for the lock to be released.
  typedef enum logic [2:0] {
    RSN_NONE          = 3'd0,
    RSN_STALLED       = 3'd1,
    RSN_POS_CEILING   = 3'd2,
    RSN_DRAINED       = 3'd3,
    RSN_GRACE         = 3'd4,
    RSN_QUEUE_CEILING = 3'd5
  } reason_e;

  typedef struct packed {
    logic [RegW-1:0] grace_ms;
    logic [RegW-1:0] stall_ms;
    logic [RegW-1:0] ceiling_ms;
    logic [RegW-1:0] move_threshold_sq;
  } cfg_t;

  typedef struct packed {
    logic                    session_active;
    logic [TimeW-1:0]        armed_time;
    logic [TimeW-1:0]        expiry_time;
    logic                    saw_pending;
    logic                    have_progress;
    logic signed [PosW-1:0]  progress_x;
    logic signed [PosW-1:0]  progress_y;
    logic [TimeW-1:0]        progress_time;
  } state_t;

  typedef struct packed {
    mode_e                    mode;
    logic [TimeW-1:0]         now_ms;
    logic                     control_ok;
    logic signed [DepthW-1:0] queue_depth;
    logic                     position_valid;
    logic signed [PosW-1:0]   pos_x;
    logic signed [PosW-1:0]   pos_y;
  } item_t;

  typedef struct packed {
    logic    accepted;
    logic    restore_request;
    reason_e restore_reason;
    logic    lock_active;
  } result_t;

endpackage

// File: rtl/ilpw_decide.sv
// Decision logic for one word: next watchdog state and the result word.
module ilpw_decide import ilpw_pkg::*; (
  input  cfg_t    cfg_i,
  input  state_t  state_i,
  input  item_t   item_i,
  output state_t  state_o,
  output result_t result_o
);

  localparam int unsigned DiffW = PosW + 1;
  localparam int unsigned SqInW = 16;
  localparam int unsigned SqW   = 2 * SqInW;

  logic signed [DiffW-1:0] dx, dy;
  logic [DiffW-1:0]        abs_x, abs_y;
  logic                    far_x, far_y;
  logic [SqW-1:0]          sq_x, sq_y;
  logic [SqW:0]            dist_sq;
  logic                    moved;

  // Exact differences in Q16.8 and their magnitudes.
  assign dx = {item_i.pos_x[PosW-1], item_i.pos_x}
            - {state_i.progress_x[PosW-1], state_i.progress_x};
  assign dy = {item_i.pos_y[PosW-1], item_i.pos_y}
            - {state_i.progress_y[PosW-1], state_i.progress_y};
  assign abs_x = dx[DiffW-1] ? DiffW'(-dx) : DiffW'(dx);
  assign abs_y = dy[DiffW-1] ? DiffW'(-dy) : DiffW'(dy);

  // A magnitude of 2^16 or more squares to at least 2^32, which beats any
  // threshold, so only the low 16 bits ever need squaring.
  assign far_x   = |abs_x[DiffW-1:SqInW];
  assign far_y   = |abs_y[DiffW-1:SqInW];
  assign sq_x    = abs_x[SqInW-1:0] * abs_x[SqInW-1:0];
  assign sq_y    = abs_y[SqInW-1:0] * abs_y[SqInW-1:0];
  assign dist_sq = {1'b0, sq_x} + {1'b0, sq_y};
  assign moved   = far_x || far_y || (dist_sq >= {1'b0, cfg_i.move_threshold_sq});

  // Set calls, ticks and the restore decision.
  always_comb begin
    logic populated;
    logic empty_q;
    reason_e reason;
    populated = !item_i.queue_depth[DepthW-1] && (item_i.queue_depth != '0);
    empty_q   = (item_i.queue_depth == '0);
    reason    = RSN_NONE;
    state_o   = state_i;
    result_o  = '{accepted: 1'b0, restore_request: 1'b0,
                  restore_reason: RSN_NONE, lock_active: 1'b0};

    if (item_i.mode != MODE_TICK) begin
      if (item_i.control_ok) begin
        result_o.accepted = 1'b1;
        case (item_i.mode)
          MODE_ENABLE: begin
            state_o.session_active = 1'b0;
            state_o.expiry_time    = '0;
            state_o.saw_pending    = 1'b0;
            state_o.have_progress  = 1'b0;
          end
          MODE_ARM: begin
            if (!state_i.session_active) begin
              state_o.session_active = 1'b1;
              state_o.armed_time     = item_i.now_ms;
              state_o.expiry_time    = item_i.now_ms + cfg_i.ceiling_ms;
              state_o.saw_pending    = 1'b0;
              state_o.have_progress  = 1'b0;
            end
          end
          MODE_SUSTAIN: begin
            state_o.session_active = 1'b0;
            state_o.expiry_time    = '0;
          end
          default: begin
          end
        endcase
      end
    end else if (state_i.session_active) begin
      if (populated) begin
        state_o.saw_pending = 1'b1;
        if (item_i.position_valid) begin
          if (!state_i.have_progress || moved) begin
            state_o.progress_x    = item_i.pos_x;
            state_o.progress_y    = item_i.pos_y;
            state_o.progress_time = item_i.now_ms;
            state_o.have_progress = 1'b1;
          end else if ((item_i.now_ms - state_i.progress_time) >= cfg_i.stall_ms) begin
            reason = RSN_STALLED;
          end
        end else if (item_i.now_ms >= state_i.expiry_time) begin
          reason = RSN_POS_CEILING;
        end
      end else if (empty_q) begin
        if (state_i.saw_pending) begin
          reason = RSN_DRAINED;
        end else if ((item_i.now_ms - state_i.armed_time) >= cfg_i.grace_ms) begin
          reason = RSN_GRACE;
        end
      end else if (item_i.now_ms >= state_i.expiry_time) begin
        reason = RSN_QUEUE_CEILING;
      end

      // A restore only clears the session when the release call succeeds.
      if (reason != RSN_NONE) begin
        result_o.restore_request = 1'b1;
        if (item_i.control_ok) begin
          result_o.accepted      = 1'b1;
          state_o.session_active = 1'b0;
          state_o.expiry_time    = '0;
          state_o.saw_pending    = 1'b0;
          state_o.have_progress  = 1'b0;
        end
      end
    end

    result_o.restore_reason = reason;
    result_o.lock_active    = state_o.session_active;
  end

endmodule

// File: rtl/input_lock_progress_watchdog_top.sv
// Top level of the input lock progress watchdog: registers, handshake and state.
// A word moves from the input register to the result register; the state loop closes
// through one decision pass; one word per cycle unless the output stalls.
// The result register holds a finished word while the next one is taken in.
// Reset clears the session state, both valid flags and restores register defaults.
module input_lock_progress_watchdog_top import ilpw_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [RegW-1:0]          cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               mode_i,
  input  logic [TimeW-1:0]         now_ms_i,
  input  logic                     control_ok_i,
  input  logic signed [DepthW-1:0] queue_depth_i,
  input  logic                     position_valid_i,
  input  logic signed [PosW-1:0]   pos_x_i,
  input  logic signed [PosW-1:0]   pos_y_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     accepted_o,
  output logic                     restore_request_o,
  output logic [2:0]               restore_reason_o,
  output logic                     lock_active_o
);

  cfg_t    cfg_q;
  state_t  state_q, state_d;
  item_t   item_q;
  logic    item_valid_q;
  result_t res_q, res_d;
  logic    out_valid_q;
  logic    advance;

  // The input stage moves on whenever the result register is free or drains.
  assign advance    = item_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || advance;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grace_ms          <= GraceReset;
      cfg_q.stall_ms          <= StallReset;
      cfg_q.ceiling_ms        <= CeilingReset;
      cfg_q.move_threshold_sq <= ThresholdReset;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_GRACE:     cfg_q.grace_ms          <= cfg_wdata_i;
        REG_STALL:     cfg_q.stall_ms          <= cfg_wdata_i;
        REG_CEILING:   cfg_q.ceiling_ms        <= cfg_wdata_i;
        REG_THRESHOLD: cfg_q.move_threshold_sq <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q.mode           <= mode_e'(mode_i);
      item_q.now_ms         <= now_ms_i;
      item_q.control_ok     <= control_ok_i;
      item_q.queue_depth    <= queue_depth_i;
      item_q.position_valid <= position_valid_i;
      item_q.pos_x          <= pos_x_i;
      item_q.pos_y          <= pos_y_i;
    end
  end

  ilpw_decide u_decide (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Watchdog state, updated as each word leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign accepted_o        = res_q.accepted;
  assign restore_request_o = res_q.restore_request;
  assign restore_reason_o  = res_q.restore_reason;
  assign lock_active_o     = res_q.lock_active;

  // A restore request always carries a reason, and no request carries none.
  a_reason_matches_request : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.restore_request == (res_q.restore_reason != RSN_NONE)))
    else $error("restore reason and request disagree");

  // A restore that went through leaves no session behind.
  a_restore_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.restore_request && res_q.accepted) |-> !res_q.lock_active)
    else $error("accepted restore left the session active");

  // The reported lock state tracks the session register until the next word.
  a_lock_tracks_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.lock_active == state_q.session_active))
    else $error("lock_active does not match session state");

  // An empty result register never blocks the input side.
  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with an empty result register");

endmodule

// File: verif/tb_input_lock_progress_watchdog_top.sv
// Self-checking testbench for the input lock progress watchdog top level.
module tb_input_lock_progress_watchdog_top;
  import ilpw_pkg::*;

  // Cycles without any accepted word before the run is declared hung.
  localparam int unsigned HangLimit  = 5000;
  localparam int unsigned Blocks     = 8;
  localparam int unsigned BlockWords = 100;

  // Tracks the watchdog session and holds the results that are still due.
  class lock_watch_scoreboard;
    cfg_t        cfg;
    state_t      st;
    result_t     due_results[$];
    int unsigned mismatches;

    function new();
      cfg        = '{GraceReset, StallReset, CeilingReset, ThresholdReset};
      st         = '0;
      mismatches = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [RegW-1:0] val);
      case (idx)
        REG_GRACE:   cfg.grace_ms = val;
        REG_STALL:   cfg.stall_ms = val;
        REG_CEILING: cfg.ceiling_ms = val;
        default:     cfg.move_threshold_sq = val;
      endcase
    endfunction

    // Enable and a granted restore end the session and forget its history.
    function void drop_session();
      st.session_active = 1'b0;
      st.expiry_time    = '0;
      st.saw_pending    = 1'b0;
      st.have_progress  = 1'b0;
    endfunction

    // Works out the result of one accepted word and queues it.
    function void note_word(item_t w);
      logic signed [PosW:0]  dx, dy;
      logic [2*PosW+1:0]     dist_sq;
      result_t               r;
      r = '{1'b0, 1'b0, RSN_NONE, 1'b0};
      if (w.mode != MODE_TICK) begin
        if (w.control_ok) begin
          r.accepted = 1'b1;
          case (w.mode)
            MODE_ENABLE: drop_session();
            MODE_ARM: begin
              // A repeat arm leaves the running session and its expiry alone.
              if (!st.session_active) begin
                st.session_active = 1'b1;
                st.armed_time     = w.now_ms;
                st.expiry_time    = w.now_ms + cfg.ceiling_ms;
                st.saw_pending    = 1'b0;
                st.have_progress  = 1'b0;
              end
            end
            default: begin
              st.session_active = 1'b0;
              st.expiry_time    = '0;
            end
          endcase
        end
      end else if (st.session_active) begin
        if ($signed(w.queue_depth) > 0) begin
          st.saw_pending = 1'b1;
          if (w.position_valid) begin
            dx      = $signed(w.pos_x) - $signed(st.progress_x);
            dy      = $signed(w.pos_y) - $signed(st.progress_y);
            dist_sq = dx * dx + dy * dy;
            if (!st.have_progress || dist_sq >= cfg.move_threshold_sq) begin
              st.progress_x    = w.pos_x;
              st.progress_y    = w.pos_y;
              st.progress_time = w.now_ms;
              st.have_progress = 1'b1;
            end else if (w.now_ms - st.progress_time >= cfg.stall_ms) begin
              r.restore_reason = RSN_STALLED;
            end
          end else if (w.now_ms >= st.expiry_time) begin
            r.restore_reason = RSN_POS_CEILING;
          end
        end else if ($signed(w.queue_depth) == 0) begin
          if (st.saw_pending) begin
            r.restore_reason = RSN_DRAINED;
          end else if (w.now_ms - st.armed_time >= cfg.grace_ms) begin
            r.restore_reason = RSN_GRACE;
          end
        end else if (w.now_ms >= st.expiry_time) begin
          r.restore_reason = RSN_QUEUE_CEILING;
        end
        // A restore is always reported, but only a granted one ends the session.
        if (r.restore_reason != RSN_NONE) begin
          r.restore_request = 1'b1;
          if (w.control_ok) begin
            r.accepted = 1'b1;
            drop_session();
          end
        end
      end
      r.lock_active = st.session_active;
      due_results.push_back(r);
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        $error("unexpected result: accepted %0b request %0b reason %0d lock %0b",
               got.accepted, got.restore_request, got.restore_reason, got.lock_active);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      if (got.accepted !== want.accepted) begin
        $error("accepted: expected %0b, got %0b", want.accepted, got.accepted);
        mismatches++;
      end
      if (got.restore_request !== want.restore_request) begin
        $error("restore_request: expected %0b, got %0b",
               want.restore_request, got.restore_request);
        mismatches++;
      end
      if (got.restore_reason !== want.restore_reason) begin
        $error("restore_reason: expected %0d, got %0d",
               want.restore_reason, got.restore_reason);
        mismatches++;
      end
      if (got.lock_active !== want.lock_active) begin
        $error("lock_active: expected %0b, got %0b", want.lock_active, got.lock_active);
        mismatches++;
      end
    endfunction
  endclass

  logic                     clk_i            = 1'b0;
  logic                     rst_ni           = 1'b0;
  logic                     cfg_we_i         = 1'b0;
  logic [CfgIdxW-1:0]       cfg_idx_i        = '0;
  logic [RegW-1:0]          cfg_wdata_i      = '0;
  logic                     in_valid_i       = 1'b0;
  logic                     in_ready_o;
  logic [1:0]               mode_i           = '0;
  logic [TimeW-1:0]         now_ms_i         = '0;
  logic                     control_ok_i     = 1'b0;
  logic signed [DepthW-1:0] queue_depth_i    = '0;
  logic                     position_valid_i = 1'b0;
  logic signed [PosW-1:0]   pos_x_i          = '0;
  logic signed [PosW-1:0]   pos_y_i          = '0;
  logic                     out_valid_o;
  logic                     out_ready_i      = 1'b0;
  logic                     accepted_o;
  logic                     restore_request_o;
  logic [2:0]               restore_reason_o;
  logic                     lock_active_o;

  lock_watch_scoreboard sb = new();
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned idle_cycles    = 0;

  input_lock_progress_watchdog_top DUT (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Result side: check every accepted word, then pick the next ready level.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_word('{accepted_o, restore_request_o, reason_e'(restore_reason_o),
                      lock_active_o});
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Hang detector: any accepted word on either side restarts the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HangLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic item_t make_word(mode_e m, logic [TimeW-1:0] t, logic ok,
                                      logic signed [DepthW-1:0] depth, logic pv,
                                      logic signed [PosW-1:0] x,
                                      logic signed [PosW-1:0] y);
    item_t w;
    w.mode           = m;
    w.now_ms         = t;
    w.control_ok     = ok;
    w.queue_depth    = depth;
    w.position_valid = pv;
    w.pos_x          = x;
    w.pos_y          = y;
    return w;
  endfunction

  // Offers one word, with an optional random idle stretch first, and notes it once taken.
  task automatic send_word(item_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i       <= 1'b1;
    mode_i           <= w.mode;
    now_ms_i         <= w.now_ms;
    control_ok_i     <= w.control_ok;
    queue_depth_i    <= w.queue_depth;
    position_valid_i <= w.position_valid;
    pos_x_i          <= w.pos_x;
    pos_y_i          <= w.pos_y;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(w);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [RegW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  initial begin : stimulus
    item_t                    script[$];
    cfg_t                     setting;
    logic [TimeW-1:0]         clock_ms;
    logic signed [PosW-1:0]   at_x, at_y;
    logic signed [DepthW-1:0] depth;
    mode_e                    op;
    logic                     ok, pv;
    int unsigned              pick;
    int unsigned              send_pct [4];
    int unsigned              recv_pct [4];

    send_pct = '{0, 75, 0, 33};
    recv_pct = '{0, 0, 75, 33};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words with the reset settings: each operation and edge case.
    script.push_back(make_word(MODE_TICK, 50, 1, 100, 1, 0, 0));       // tick, no session
    script.push_back(make_word(MODE_ARM, 100, 0, 0, 0, 0, 0));         // failed set call
    script.push_back(make_word(MODE_ENABLE, 100, 1, 0, 0, 0, 0));
    script.push_back(make_word(MODE_ARM, 1000, 1, 0, 0, 0, 0));
    script.push_back(make_word(MODE_ARM, 2000, 1, 0, 0, 0, 0));        // repeat arm
    script.push_back(make_word(MODE_TICK, 1100, 1, 0, 0, 0, 0));       // inside grace
    script.push_back(make_word(MODE_TICK, 1300, 0, 0, 0, 0, 0));       // grace, refused
    script.push_back(make_word(MODE_TICK, 1300, 1, 0, 0, 0, 0));       // grace, granted
    script.push_back(make_word(MODE_ARM, 2000, 1, 0, 0, 0, 0));
    script.push_back(make_word(MODE_TICK, 2100, 1, 5, 1, 0, 0));       // first fix
    script.push_back(make_word(MODE_TICK, 3000, 1, 5, 1, 10, 10));     // small move
    script.push_back(make_word(MODE_TICK, 6100, 1, 5, 1, 10, 10));     // stalled
    script.push_back(make_word(MODE_ARM, 10000, 1, 0, 0, 0, 0));
    script.push_back(make_word(MODE_TICK, 12000, 1, 3, 0, 0, 0));      // no fix, early
    script.push_back(make_word(MODE_TICK, 18000, 1, 3, 0, 0, 0));      // no fix, expired
    script.push_back(make_word(MODE_ARM, 20000, 1, 0, 0, 0, 0));
    script.push_back(make_word(MODE_TICK, 20001, 1, 65535, 1, 24'sh7FFFFF, 24'sh7FFFFF));
    script.push_back(make_word(MODE_TICK, 20002, 1, 1, 1, 24'sh800000, 24'sh800000));
    script.push_back(make_word(MODE_ENABLE, 20003, 1, 0, 0, 0, 0));    // enable mid session
    script.push_back(make_word(MODE_ARM, 32'hFFFF_F000, 1, 0, 0, 0, 0)); // expiry wraps
    script.push_back(make_word(MODE_TICK, 32'hFFFF_F100, 0, -1, 0, 0, 0));
    script.push_back(make_word(MODE_TICK, 32'hFFFF_F180, 0, 2, 0, 0, 0));
    script.push_back(make_word(MODE_TICK, 32'hFFFF_F200, 1, 0, 0, 0, 0)); // drained
    script.push_back(make_word(MODE_ARM, 5, 1, 0, 0, 0, 0));
    script.push_back(make_word(MODE_TICK, 6, 1, -1, 0, 0, 0));         // unreadable, early
    script.push_back(make_word(MODE_SUSTAIN, 7, 1, 0, 0, 0, 0));
    foreach (script[i]) send_word(script[i]);

    clock_ms = $urandom();
    at_x     = '0;
    at_y     = '0;
    for (int blk = 0; blk < Blocks; blk++) begin
      // Settings change only once the block has drained.
      in_valid_i <= 1'b0;
      while (sb.due_results.size() != 0) @(posedge clk_i);
      repeat (4) @(posedge clk_i);
      case (blk)
        0:       setting = '{GraceReset, StallReset, CeilingReset, ThresholdReset};
        1:       setting = '0;
        2:       setting = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        4:       setting = '{32'hFFFF_FFFF, 32'd0, $urandom(), 32'hFFFF_FFFF};
        default: setting = '{$urandom_range(1000), $urandom_range(3000),
                             $urandom_range(10000), $urandom_range(200000)};
      endcase
      write_reg(REG_GRACE, setting.grace_ms);
      write_reg(REG_STALL, setting.stall_ms);
      write_reg(REG_CEILING, setting.ceiling_ms);
      write_reg(REG_THRESHOLD, setting.move_threshold_sq);
      send_idle_pct  = send_pct[blk % 4];
      recv_stall_pct = recv_pct[blk % 4];

      for (int n = 0; n < BlockWords; n++) begin
        // Time mostly creeps forward, with some long gaps and jumps anywhere.
        pick = $urandom_range(99);
        if (pick < 70) clock_ms += $urandom_range(100);
        else if (pick < 95) clock_ms += $urandom_range(6000, 100);
        else clock_ms = $urandom();

        // The position mostly holds or jitters, sometimes moves far.
        pick = $urandom_range(99);
        if (pick < 5) begin
          at_x = PosW'($urandom());
          at_y = PosW'($urandom());
        end else if (pick < 40) begin
          at_x += PosW'(int'($urandom_range(800)) - 400);
          at_y += PosW'(int'($urandom_range(800)) - 400);
        end else if (pick < 60) begin
          at_x += PosW'(int'($urandom_range(40)) - 20);
          at_y += PosW'(int'($urandom_range(40)) - 20);
        end

        // Sessions mostly arm, then run on ticks until something ends them.
        pick = $urandom_range(99);
        if (sb.st.session_active) begin
          if (pick < 80) op = MODE_TICK;
          else if (pick < 88) op = MODE_ARM;
          else if (pick < 94) op = MODE_ENABLE;
          else op = MODE_SUSTAIN;
        end else begin
          if (pick < 60) op = MODE_ARM;
          else if (pick < 85) op = MODE_TICK;
          else if (pick < 93) op = MODE_ENABLE;
          else op = MODE_SUSTAIN;
        end

        pick = $urandom_range(99);
        if (pick < 50) depth = DepthW'($urandom_range(20, 1));
        else if (pick < 70) depth = '0;
        else if (pick < 85) depth = '1;
        else depth = DepthW'($urandom_range(65535));

        ok = ($urandom_range(99) < 85);
        pv = ($urandom_range(99) < 85);
        send_word(make_word(op, clock_ms, ok, depth, pv, at_x, at_y));
      end
    end

    in_valid_i <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/ilpw_pkg.sv
rtl/ilpw_decide.sv
rtl/input_lock_progress_watchdog_top.sv
verif/tb_input_lock_progress_watchdog_top.sv
